>>> rtl/scc_pkg.sv
// Shared types for the sector cache tag and replacement block:
// request and result beats, controller states, command and status groups.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int SLOT_W        = 6;
    localparam int SECTOR_W      = 32;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_PREFETCH = 2'd2,
        OP_FLUSH    = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 operation;
        logic [SECTOR_W-1:0] sector;
    } t_req;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                need_fill;
        logic [SECTOR_W-1:0] fill_sector;
        logic                need_write_back;
        logic [SECTOR_W-1:0] write_sector;
        logic                last;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN,
        ST_VICTIM,
        ST_FLUSH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture request, clear index
        logic rd_en;       // read tag at index
        logic idx_inc;     // plain index advance
        logic idx_clr;
        logic hit_done;    // report hit from read stage
        logic fill_new;    // fill next free slot
        logic scan_clear;  // clear accessed mark at index, advance with wrap
        logic evict;       // replace victim held in read stage
        logic flush_run;
        logic flush_end;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic idx_lt_used;
        logic match;
        logic rd_vld;
        logic full;
        logic acc_at_idx;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/scc_ctrl.sv
// Controller state machine of the sector cache block.
// Drives t_cmd to the datapath from t_sts; depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_ctrl
    import scc_pkg::*;
(
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_start,
    input  wire  t_op  i_op,
    input  wire  t_sts i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_op == OP_FLUSH) ? ST_FLUSH : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_sts.match) begin
                    o_cmd.hit_done = 1'b1;
                    n_state        = ST_IDLE;
                end else if (i_sts.idx_lt_used) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end else if (!i_sts.rd_vld) begin
                    if (i_sts.full) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = ST_SCAN;
                    end else begin
                        o_cmd.fill_new = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                // second chance: drop the mark and move on, else take this slot
                if (i_sts.acc_at_idx) begin
                    o_cmd.scan_clear = 1'b1;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_VICTIM;
                end
            end
            ST_VICTIM: begin
                o_cmd.evict = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_FLUSH: begin
                o_cmd.flush_run = 1'b1;
                if (i_sts.idx_lt_used) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end else if (!i_sts.rd_vld) begin
                    o_cmd.flush_end = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/scc_datapath.sv
// Datapath of the sector cache block: tag memory, accessed and dirty marks,
// fill count, scan index, read stage and result register. Depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_datapath
    import scc_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  t_req i_req,
    input  wire  t_cmd i_cmd,
    output t_sts       o_sts,
    output logic       o_res_valid,
    output t_res       o_res
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    logic [SECTOR_W-1:0] r_mem [NUM_SLOTS];

    logic [SECTOR_W-1:0]  r_target;
    t_op                  r_op;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_used;
    logic [NUM_SLOTS-1:0] r_acc;
    logic [NUM_SLOTS-1:0] r_dirty;

    logic                 r_rd_vld;
    logic [SECTOR_W-1:0]  r_rd_data;
    logic [SW-1:0]        r_rd_idx;
    logic                 r_rd_dirty;

    logic                 r_pend_vld;
    logic [SW-1:0]        r_pend_slot;
    logic [SECTOR_W-1:0]  r_pend_sec;

    logic                 r_res_vld;
    t_res                 r_res;

    logic [SW-1:0]        idx_s;
    logic [SW-1:0]        used_s;
    logic                 wr_en;
    logic [SW-1:0]        wr_addr;
    logic                 flush_hit;

    assign idx_s     = r_idx[SW-1:0];
    assign used_s    = r_used[SW-1:0];
    assign wr_en     = i_cmd.fill_new | i_cmd.evict;
    assign wr_addr   = i_cmd.fill_new ? used_s : r_rd_idx;
    assign flush_hit = i_cmd.flush_run & r_rd_vld & r_rd_dirty;

    assign o_sts.idx_lt_used = (r_idx < r_used);
    assign o_sts.match       = r_rd_vld & (r_rd_data == r_target);
    assign o_sts.rd_vld      = r_rd_vld;
    assign o_sts.full        = (r_used == CW'(NUM_SLOTS));
    assign o_sts.acc_at_idx  = r_acc[idx_s];

    // tag memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_target;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[idx_s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= (i_req.operation == OP_PREFETCH) ? i_req.sector + 32'd1
                                                         : i_req.sector;
            r_op     <= i_req.operation;
        end
        if (i_cmd.rd_en) begin
            r_rd_idx   <= idx_s;
            r_rd_dirty <= r_dirty[idx_s];
        end
        if (flush_hit) begin
            r_pend_slot <= r_rd_idx;
            r_pend_sec  <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_used     <= '0;
            r_acc      <= '0;
            r_dirty    <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.rd_en;
            r_res_vld <= 1'b0;

            if (i_cmd.load || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end else if (i_cmd.scan_clear) begin
                r_idx <= (idx_s == SW'(NUM_SLOTS - 1)) ? '0 : r_idx + CW'(1);
            end

            if (i_cmd.load) begin
                r_pend_vld <= 1'b0;
            end

            if (i_cmd.scan_clear) begin
                r_acc[idx_s] <= 1'b0;
            end

            // flush: clear the dirty mark as it is read
            if (i_cmd.flush_run && i_cmd.rd_en) begin
                r_dirty[idx_s] <= 1'b0;
            end

            if (i_cmd.hit_done) begin
                if (r_op != OP_PREFETCH) begin
                    r_acc[r_rd_idx] <= 1'b1;
                end
                if (r_op == OP_WRITE) begin
                    r_dirty[r_rd_idx] <= 1'b1;
                end
                r_res_vld <= 1'b1;
                r_res     <= '{hit: 1'b1, slot: SLOT_W'(r_rd_idx), need_fill: 1'b0,
                               fill_sector: '0, need_write_back: 1'b0,
                               write_sector: '0, last: 1'b1};
            end

            if (i_cmd.fill_new) begin
                r_acc[used_s]   <= 1'b1;
                r_dirty[used_s] <= (r_op == OP_WRITE);
                r_used          <= r_used + CW'(1);
                r_res_vld       <= 1'b1;
                r_res           <= '{hit: 1'b0, slot: SLOT_W'(used_s), need_fill: 1'b1,
                                     fill_sector: r_target, need_write_back: 1'b0,
                                     write_sector: '0, last: 1'b1};
            end

            if (i_cmd.evict) begin
                r_acc[r_rd_idx]   <= 1'b1;
                r_dirty[r_rd_idx] <= (r_op == OP_WRITE);
                r_res_vld         <= 1'b1;
                r_res             <= '{hit: 1'b0, slot: SLOT_W'(r_rd_idx), need_fill: 1'b1,
                                       fill_sector: r_target,
                                       need_write_back: r_dirty[r_rd_idx],
                                       write_sector: r_dirty[r_rd_idx] ? r_rd_data : '0,
                                       last: 1'b1};
            end

            // hold one dirty entry back so the final one can carry last
            if (flush_hit) begin
                r_pend_vld <= 1'b1;
                if (r_pend_vld) begin
                    r_res_vld <= 1'b1;
                    r_res     <= '{hit: 1'b0, slot: SLOT_W'(r_pend_slot), need_fill: 1'b0,
                                   fill_sector: '0, need_write_back: 1'b1,
                                   write_sector: r_pend_sec, last: 1'b0};
                end
            end

            if (i_cmd.flush_end) begin
                r_res_vld  <= 1'b1;
                r_pend_vld <= 1'b0;
                if (r_pend_vld) begin
                    r_res <= '{hit: 1'b0, slot: SLOT_W'(r_pend_slot), need_fill: 1'b0,
                               fill_sector: '0, need_write_back: 1'b1,
                               write_sector: r_pend_sec, last: 1'b1};
                end else begin
                    r_res <= '{hit: 1'b0, slot: '0, need_fill: 1'b0, fill_sector: '0,
                               need_write_back: 1'b0, write_sector: '0, last: 1'b1};
                end
            end
        end
    end

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule

`default_nettype wire

>>> rtl/sector_cache_clock_replacement.sv
// Top level of the sector cache tag and replacement block (second-chance).
// Instantiates scc_ctrl and scc_datapath; depends on scc_pkg.
//
//   channel   ports                      beat moves when
//   request   i_start, i_req, o_busy     i_start high and o_busy low
//   result    o_res_valid, o_res         o_res_valid high (one cycle each)
//
// One request at a time. Tags sit in a single-port memory read one slot per
// cycle, so a lookup reads the slots in use in order until one matches; a
// miss on a full cache adds the second-chance scan of up to NUM_SLOTS + 1
// slots plus one victim read. A flush reads every slot in use.
// Reset clears fill count and marks at once; tags need no clearing.
// Results cannot be held off; each appears for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module sector_cache_clock_replacement
    import scc_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_start,
    input  wire  t_req i_req,
    output logic       o_busy,
    output logic       o_res_valid,
    output t_res       o_res
);

    t_cmd cmd;
    t_sts sts;

    scc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_req.operation),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    scc_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
